@@ hdl/dcacd_pkg.sv @@
`timescale 1ns / 1ps

package dcacd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BAND_W = 10;
  // ref * band_permille and 1000 * |avg - ref| both fit here
  localparam int unsigned PROD_W = SAMPLE_W + BAND_W;

  localparam logic [BAND_W-1:0] BAND_RESET = 10'd125;
  localparam int unsigned PERMILLE_SCALE = 1000;
  localparam int unsigned DEFAULT_SAMPLES_PER_WINDOW = 5;

  // result queue
  localparam int unsigned RESULT_DEPTH = 8;
  localparam int unsigned RESULT_PTR_W = $clog2(RESULT_DEPTH);
  localparam int unsigned RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

  localparam logic CHANNEL_0 = 1'b0;
  localparam logic CHANNEL_1 = 1'b1;

  typedef struct packed {
    logic                channel;
    logic [SAMPLE_W-1:0] window_average;
    logic                last_of_run;
  } result_t;

endpackage

@@ hdl/dual_channel_average_change_detector_core.sv @@
`timescale 1ns / 1ps

// Dual channel block-average change detector. Each input beat carries one
// 16-bit sample per channel. Every SAMPLES_PER_WINDOW beats the block forms
// each channel's truncated window average and compares it with that
// channel's last reported average (its reference); an average that leaves
// reference +/- floor(reference * band_permille / 1000) is reported as a
// result beat and becomes the new reference for that channel only. A full
// window yields zero, one or two result beats; channel 0 comes first, and
// last_of_run marks the final one of the window. The input takes one beat
// per clock while in_stall is low. The closing beat latches the window sums
// in stage A, stage B registers the reciprocal multiply that divides by the
// window length, and the band test on stage B's result writes into an
// 8-entry result queue, whose head is offered on the result channel. The
// input stalls only when that queue lacks room for two results for every
// window still in flight plus two for the beat on offer, so with a
// free-running consumer a window of two or more beats never stalls.
// band_permille is written through the cfg port (always ready); the user
// must write it only while idle, which the block does not enforce. It
// resets to 125.

module dual_channel_average_change_detector_core #(
  parameter int unsigned SAMPLES_PER_WINDOW = dcacd_pkg::DEFAULT_SAMPLES_PER_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dcacd_pkg::SAMPLE_W-1:0]       sample_ch0,
  input  logic [dcacd_pkg::SAMPLE_W-1:0]       sample_ch1,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 channel,
  output logic [dcacd_pkg::SAMPLE_W-1:0]       window_average,
  output logic                                 last_of_run,
  // band register write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dcacd_pkg::BAND_W-1:0]         band_permille
);

  localparam int unsigned SW = dcacd_pkg::SAMPLE_W;
  localparam int unsigned LOG2N = $clog2(SAMPLES_PER_WINDOW);
  localparam int unsigned SUM_W = SW + LOG2N;
  localparam int unsigned CNT_W = (SAMPLES_PER_WINDOW > 1) ? LOG2N : 1;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_WINDOW - 1);

  // floor(x / N) == (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int unsigned SHIFT = SUM_W + LOG2N;
  localparam int unsigned MUL_W = SUM_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + SAMPLES_PER_WINDOW - 1) / SAMPLES_PER_WINDOW;
  localparam int unsigned QPROD_W = SUM_W + MUL_W;

  localparam int unsigned PW = dcacd_pkg::PROD_W;
  localparam int unsigned DEPTH = dcacd_pkg::RESULT_DEPTH;
  localparam int unsigned PTR_W = dcacd_pkg::RESULT_PTR_W;
  localparam int unsigned QCNT_W = dcacd_pkg::RESULT_CNT_W;
  localparam int unsigned CRED_W = QCNT_W + 2;

  // ---------------------------------------------------------------
  // band register
  // ---------------------------------------------------------------
  logic [dcacd_pkg::BAND_W-1:0] band;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= dcacd_pkg::BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      band <= band_permille;
    end
  end

  // ---------------------------------------------------------------
  // window accumulation
  // ---------------------------------------------------------------
  logic             in_beat;
  logic [CNT_W-1:0] window_count;
  logic [SUM_W-1:0] sum_ch0, sum_ch1;
  logic [SUM_W-1:0] sum_ch0_next, sum_ch1_next;
  logic             window_done;

  assign in_beat      = in_valid && !in_stall;
  assign sum_ch0_next = sum_ch0 + SUM_W'(sample_ch0);
  assign sum_ch1_next = sum_ch1 + SUM_W'(sample_ch1);
  assign window_done  = (window_count == LAST_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      sum_ch0      <= '0;
      sum_ch1      <= '0;
    end else if (in_beat) begin
      if (window_done) begin
        window_count <= '0;
        sum_ch0      <= '0;
        sum_ch1      <= '0;
      end else begin
        window_count <= window_count + CNT_W'(1);
        sum_ch0      <= sum_ch0_next;
        sum_ch1      <= sum_ch1_next;
      end
    end
  end

  // stage A: full window sums
  logic             a_valid;
  logic [SUM_W-1:0] a_sum0, a_sum1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_beat && window_done;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && window_done) begin
      a_sum0 <= sum_ch0_next;
      a_sum1 <= sum_ch1_next;
    end
  end

  // ---------------------------------------------------------------
  // stage B: divide by the window length (reciprocal multiply)
  // ---------------------------------------------------------------
  logic [QPROD_W-1:0] qprod0, qprod1;
  logic               b_valid;
  logic [SW-1:0]      b_avg0, b_avg1;

  assign qprod0 = QPROD_W'(a_sum0) * QPROD_W'(MUL_W'(RECIP));
  assign qprod1 = QPROD_W'(a_sum1) * QPROD_W'(MUL_W'(RECIP));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_avg0 <= qprod0[SHIFT +: SW];
      b_avg1 <= qprod1[SHIFT +: SW];
    end
  end

  // ---------------------------------------------------------------
  // stage C: band test
  // avg is outside ref +/- floor(ref*band/1000) exactly when
  // 1000 * |avg - ref| > ref * band, which also covers band > ref.
  // ---------------------------------------------------------------
  logic [SW-1:0] reference_ch0, reference_ch1;
  logic [SW-1:0] diff0, diff1;
  logic [PW-1:0] scaled0, scaled1, limit0, limit1;
  logic          fire0, fire1;

  assign diff0 = (b_avg0 >= reference_ch0) ? (b_avg0 - reference_ch0)
                                           : (reference_ch0 - b_avg0);
  assign diff1 = (b_avg1 >= reference_ch1) ? (b_avg1 - reference_ch1)
                                           : (reference_ch1 - b_avg1);

  assign scaled0 = PW'(diff0) * PW'(dcacd_pkg::PERMILLE_SCALE);
  assign scaled1 = PW'(diff1) * PW'(dcacd_pkg::PERMILLE_SCALE);
  assign limit0  = PW'(reference_ch0) * PW'(band);
  assign limit1  = PW'(reference_ch1) * PW'(band);

  assign fire0 = b_valid && (scaled0 > limit0);
  assign fire1 = b_valid && (scaled1 > limit1);

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ch0 <= '0;
      reference_ch1 <= '0;
    end else begin
      if (fire0) begin
        reference_ch0 <= b_avg0;
      end
      if (fire1) begin
        reference_ch1 <= b_avg1;
      end
    end
  end

  // ---------------------------------------------------------------
  // result queue, up to two pushes per cycle
  // ---------------------------------------------------------------
  dcacd_pkg::result_t queue [DEPTH];
  dcacd_pkg::result_t res0, res1, head;
  logic [PTR_W-1:0]   wr_ptr, rd_ptr, wr_ptr_ch1;
  logic [QCNT_W-1:0]  q_count;
  logic [QCNT_W-1:0]  q_count_next;
  logic               out_beat;
  logic [CRED_W-1:0]  credit_need;

  assign res0.channel        = dcacd_pkg::CHANNEL_0;
  assign res0.window_average = b_avg0;
  assign res0.last_of_run    = !fire1;
  assign res1.channel        = dcacd_pkg::CHANNEL_1;
  assign res1.window_average = b_avg1;
  assign res1.last_of_run    = 1'b1;

  assign wr_ptr_ch1 = fire0 ? (wr_ptr + PTR_W'(1)) : wr_ptr;
  assign out_beat   = out_valid && !out_stall;

  assign q_count_next = q_count + QCNT_W'(fire0) + QCNT_W'(fire1)
                      - QCNT_W'(out_beat);

  always_ff @(posedge clk) begin
    if (fire0) begin
      queue[wr_ptr] <= res0;
    end
    if (fire1) begin
      queue[wr_ptr_ch1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + PTR_W'(fire0) + PTR_W'(fire1);
      rd_ptr  <= rd_ptr + PTR_W'(out_beat);
      q_count <= q_count_next;
    end
  end

  assign head           = queue[rd_ptr];
  assign out_valid      = (q_count != '0);
  assign channel        = head.channel;
  assign window_average = head.window_average;
  assign last_of_run    = head.last_of_run;

  // reserve two queue slots per window in flight plus two for this beat
  assign credit_need = CRED_W'(q_count) + CRED_W'({a_valid, 1'b0})
                     + CRED_W'({b_valid, 1'b0}) + CRED_W'(2);
  assign in_stall    = (credit_need > CRED_W'(DEPTH));

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    (CRED_W'(q_count) + CRED_W'({a_valid, 1'b0}) + CRED_W'({b_valid, 1'b0}))
      <= CRED_W'(DEPTH))
    else $error("result queue reservation exceeded");

  a_stage_follow : assert property (@(posedge clk) disable iff (rst)
    a_valid |=> b_valid)
    else $error("window sum did not reach the divide stage");

  a_window_source : assert property (@(posedge clk) disable iff (rst)
    a_valid |-> $past(in_valid && !in_stall))
    else $error("window closed without an input beat");

  a_run_order : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (channel == dcacd_pkg::CHANNEL_0))
    else $error("only a channel 0 result may precede another in a run");

endmodule

@@ tb/sv/dual_channel_average_change_detector_core_test.sv @@
`timescale 1ns / 1ps

module dual_channel_average_change_detector_core_test;

  localparam int unsigned SAMPLE_W = dcacd_pkg::SAMPLE_W;
  localparam int unsigned BAND_W = dcacd_pkg::BAND_W;
  localparam int unsigned PERMILLE_SCALE = dcacd_pkg::PERMILLE_SCALE;
  localparam logic [BAND_W-1:0] BAND_RESET = dcacd_pkg::BAND_RESET;
  localparam logic CHANNEL_0 = dcacd_pkg::CHANNEL_0;
  localparam logic CHANNEL_1 = dcacd_pkg::CHANNEL_1;
  typedef dcacd_pkg::result_t result_t;

  localparam int unsigned WINDOW_LEN = dcacd_pkg::DEFAULT_SAMPLES_PER_WINDOW;
  localparam int FULL_SCALE = (1 << SAMPLE_W) - 1;
  // settle time past the pipeline, with margin for a window that reports nothing
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam longint unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned GAP_MAX = 8;
  localparam int unsigned PRINT_CAP = 40;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample_ch0;
  logic [SAMPLE_W-1:0] sample_ch1;
  logic                out_valid;
  logic                out_stall;
  logic                channel;
  logic [SAMPLE_W-1:0] window_average;
  logic                last_of_run;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BAND_W-1:0]   band_permille;

  // change detector shadow state
  logic [BAND_W-1:0]   band_setting;
  int unsigned         pairs_in_window;
  int unsigned         window_sum [2];
  logic [SAMPLE_W-1:0] last_reported [2];
  result_t             expected_reports [$];
  result_t             oldest_report;

  int unsigned     send_gap_max;
  int unsigned     take_gap_max;
  int unsigned     mismatch_count;
  int unsigned     pairs_sent;
  int unsigned     windows_closed;
  int unsigned     reports_seen;
  longint unsigned cycle_count;

  dual_channel_average_change_detector_core #(
    .SAMPLES_PER_WINDOW(WINDOW_LEN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_ch0    (sample_ch0),
    .sample_ch1    (sample_ch1),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel       (channel),
    .window_average(window_average),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .band_permille (band_permille)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d reports still pending", cycle_count,
               expected_reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [SAMPLE_W-1:0] fit_sample(input int v);
    if (v < 0)
      return '0;
    if (v > FULL_SCALE)
      return SAMPLE_W'(FULL_SCALE);
    return SAMPLE_W'(v);
  endfunction

  function automatic int unsigned band_of(input logic [SAMPLE_W-1:0] anchor);
    return (32'(anchor) * 32'(band_setting)) / PERMILLE_SCALE;
  endfunction

  // bounds are compared at full width, so anchor + band never wraps
  function automatic bit leaves_band(input int unsigned avg, input logic [SAMPLE_W-1:0] anchor);
    int unsigned band;
    int unsigned a;
    a = 32'(anchor);
    band = band_of(anchor);
    return ((band <= a) && (avg < a - band)) || (avg > a + band);
  endfunction

  // Fold one accepted beat into the window; on the closing beat queue the
  // reports it must cause, channel 0 first, and move the anchors.
  function automatic void fold_pair(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
    int unsigned avg [2];
    bit fires [2];
    result_t rpt;
    int c;
    window_sum[0] += 32'(s0);
    window_sum[1] += 32'(s1);
    pairs_in_window++;
    if (pairs_in_window < WINDOW_LEN)
      return;
    for (c = 0; c < 2; c++) begin
      avg[c] = (window_sum[c] / WINDOW_LEN) & FULL_SCALE;
      fires[c] = leaves_band(avg[c], last_reported[c]);
      window_sum[c] = 0;
    end
    pairs_in_window = 0;
    windows_closed++;
    for (c = 0; c < 2; c++) begin
      if (fires[c]) begin
        last_reported[c] = SAMPLE_W'(avg[c]);
        rpt.channel = (c == 0) ? CHANNEL_0 : CHANNEL_1;
        rpt.window_average = SAMPLE_W'(avg[c]);
        rpt.last_of_run = (c == 1) || !fires[1];
        expected_reports.push_back(rpt);
      end
    end
  endfunction

  // one sample beat; the shadow model is updated on the accepting edge
  task automatic send_pair(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_ch0 <= s0;
    sample_ch1 <= s1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_pair(s0, s1);
    pairs_sent++;
  endtask

  task automatic send_flat_window(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
    repeat (WINDOW_LEN) send_pair(s0, s1);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_band(input logic [BAND_W-1:0] value);
    drain_reports();
    cfg_valid <= 1'b1;
    band_permille <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    band_setting = value;
  endtask

  // average placed just inside or just outside the band around the anchor
  function automatic int band_edge_target(input logic [SAMPLE_W-1:0] anchor);
    int unsigned band;
    int lo;
    int hi;
    band = band_of(anchor);
    lo = (band <= 32'(anchor)) ? int'(32'(anchor)) - int'(band) : 0;
    hi = int'(32'(anchor)) + int'(band);
    case ($urandom_range(3))
      0:       return lo - 1;
      1:       return lo;
      2:       return hi;
      default: return hi + 1;
    endcase
  endfunction

  // Mostly shaped windows (band edge, drift around the anchor, jumps,
  // rails); about one in ten is raw noise on every sample.
  task automatic send_random_window();
    int level [2];
    int spread [2];
    int sample [2];
    int c;
    int k;
    bit noisy;
    noisy = ($urandom_range(9) == 0);
    for (c = 0; c < 2; c++) begin
      spread[c] = 0;
      case ($urandom_range(3))
        0: level[c] = band_edge_target(last_reported[c]);
        1: begin
          level[c] = int'(32'(last_reported[c]));
          spread[c] = $urandom_range(300);
        end
        2: begin
          level[c] = $urandom_range(FULL_SCALE);
          spread[c] = $urandom_range(2000);
        end
        default: level[c] = $urandom_range(1) ? FULL_SCALE : 0;
      endcase
    end
    for (k = 0; k < WINDOW_LEN; k++) begin
      for (c = 0; c < 2; c++) begin
        if (noisy)
          sample[c] = $urandom_range(FULL_SCALE);
        else
          sample[c] = level[c] + int'($urandom_range(2 * spread[c])) - spread[c];
      end
      send_pair(fit_sample(sample[0]), fit_sample(sample[1]));
    end
  endtask

  // Reset band of 125: zero anchor with zero average, both channels at full
  // scale, each channel alone, the lower bound exactly, truncating averages.
  task automatic test_directed_windows();
    send_flat_window('0, '0);
    send_flat_window(16'hFFFF, 16'hFFFF);
    // anchor 65535, band 8191: 57344 stays, 57343 leaves
    send_flat_window(16'd57344, 16'd57343);
    repeat (WINDOW_LEN - 1) send_pair('0, 16'd57343);
    send_pair(16'd4, 16'd57343);
    // sums of 6 and 327674 truncate to 1 and 65534
    repeat (WINDOW_LEN - 1) send_pair(16'd1, 16'hFFFF);
    send_pair(16'd2, 16'hFFFE);
  endtask

  // zero band, band equal to the anchor, band past the anchor, smallest band
  task automatic test_band_extremes();
    logic [BAND_W-1:0] settings [4];
    int i;
    settings = '{10'd0, 10'd1000, 10'd1023, 10'd1};
    for (i = 0; i < 4; i++) begin
      write_band(settings[i]);
      repeat (10) send_random_window();
    end
  endtask

  // four stretches, each with a fresh band and its own idling pattern
  task automatic test_random_windows();
    int seg;
    for (seg = 0; seg < 4; seg++) begin
      write_band(BAND_W'($urandom_range(1023)));
      send_gap_max = (seg == 0 || seg == 3) ? GAP_MAX : 0;
      take_gap_max = (seg == 0 || seg == 2) ? GAP_MAX : 0;
      repeat (40) send_random_window();
    end
    send_gap_max = GAP_MAX;
    take_gap_max = GAP_MAX;
  endtask

  // result side: random hold before each beat, then take it
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = $urandom_range(take_gap_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report channel %0d average %0d last %0d",
                                  channel, window_average, last_of_run));
      end else begin
        oldest_report = expected_reports.pop_front();
        if (channel !== oldest_report.channel)
          report_mismatch($sformatf("channel %0d, want %0d", channel, oldest_report.channel));
        if (window_average !== oldest_report.window_average)
          report_mismatch($sformatf("window_average %0d, want %0d (channel %0d)",
                                    window_average, oldest_report.window_average,
                                    oldest_report.channel));
        if (last_of_run !== oldest_report.last_of_run)
          report_mismatch($sformatf("last_of_run %0d, want %0d (channel %0d)",
                                    last_of_run, oldest_report.last_of_run,
                                    oldest_report.channel));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_ch0 <= '0;
    sample_ch1 <= '0;
    cfg_valid <= 1'b0;
    band_permille <= BAND_RESET;
    band_setting = BAND_RESET;
    pairs_in_window = 0;
    window_sum[0] = 0;
    window_sum[1] = 0;
    last_reported[0] = '0;
    last_reported[1] = '0;
    send_gap_max = GAP_MAX;
    take_gap_max = GAP_MAX;
    mismatch_count = 0;
    pairs_sent = 0;
    windows_closed = 0;
    reports_seen = 0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_windows();
    test_band_extremes();
    test_random_windows();
    drain_reports();

    $display("Covered %0d sample beats in %0d windows, %0d change reports checked.",
             pairs_sent, windows_closed, reports_seen);
    $display("Bands tried: reset, zero, one, 1000, 1023 and random, with and without idling.");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
